// ===== rtl/bhh_pkg.sv =====
`default_nettype none

package bhh_pkg;

    // Position of the next raw byte inside its group of three
    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_THIRD  = 2'd2
    } t_phase;

    localparam int CODE_W  = 11;
    localparam int LEN_W   = 4;
    localparam int MAX_OUT = 4;

    // Huffman code per sextet value, right aligned
    localparam logic [CODE_W-1:0] CODE_BITS [0:63] = '{
        11'h021, 11'h05d, 11'h05e, 11'h05f, 11'h060, 11'h061, 11'h062, 11'h063,
        11'h064, 11'h065, 11'h066, 11'h067, 11'h068, 11'h069, 11'h06a, 11'h06b,
        11'h06c, 11'h06d, 11'h06e, 11'h06f, 11'h070, 11'h071, 11'h072, 11'h0fc,
        11'h073, 11'h0fd, 11'h003, 11'h023, 11'h004, 11'h024, 11'h005, 11'h025,
        11'h026, 11'h027, 11'h006, 11'h074, 11'h075, 11'h028, 11'h029, 11'h02a,
        11'h007, 11'h02b, 11'h076, 11'h02c, 11'h008, 11'h009, 11'h02d, 11'h077,
        11'h078, 11'h079, 11'h07a, 11'h07b, 11'h000, 11'h001, 11'h002, 11'h019,
        11'h01a, 11'h01b, 11'h01c, 11'h01d, 11'h01e, 11'h01f, 11'h7fb, 11'h018
    };

    // Code length in bits per sextet value
    localparam logic [LEN_W-1:0] CODE_LEN [0:63] = '{
        4'd6, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd8,
        4'd7, 4'd8, 4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd6,
        4'd6, 4'd6, 4'd5, 4'd7, 4'd7, 4'd6, 4'd6, 4'd6,
        4'd5, 4'd6, 4'd7, 4'd6, 4'd5, 4'd5, 4'd6, 4'd7,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd5, 4'd5, 4'd5, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd11, 4'd6
    };

endpackage

`default_nettype wire

// ===== rtl/bhh_in_if.sv =====
`default_nettype none

// Raw byte channel
interface bhh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== rtl/bhh_out_if.sv =====
`default_nettype none

// Coded byte channel
interface bhh_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] coded_byte;
    logic       stream_done;

    modport source (output valid, output coded_byte, output stream_done, input ready);
    modport sink   (input valid, input coded_byte, input stream_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/base64_then_hpack_huffman_encoder.sv =====
`default_nettype none

// Base64 sextet splitter feeding a fixed-table Huffman bit packer. Each raw byte (with an
// end flag) is split into one or two sextets, coded, merged with the pending bits and cut
// into 0 to 4 coded bytes in the same cycle it is accepted; those bytes sit in a four-entry
// result buffer and leave one per cycle while the receiver is ready. A new byte is taken
// whenever that buffer is empty or is handing over its last byte, so the block does not take
// a new raw byte while more than one coded byte of the last one still waits (a raw byte
// causes up to 4 coded bytes at stream end). The last coded byte of a stream is padded with
// ones and flagged by stream_done; the stream state is then back at its reset values and a
// new stream may follow directly.
module base64_then_hpack_huffman_encoder (
    input wire        i_clk,
    input wire        i_rst_n,
    bhh_in_if.sink    i_in,
    bhh_out_if.source o_out
);

    localparam int ACC_W = 30;

    // Stream state
    bhh_pkg::t_phase r_phase, n_phase;
    logic [3:0]      r_left, n_left;
    logic [7:0]      r_acc, n_acc;
    logic [3:0]      r_cnt, n_cnt;

    // Result buffer
    logic [7:0]      r_bytes [bhh_pkg::MAX_OUT];
    logic [7:0]      n_bytes [bhh_pkg::MAX_OUT];
    logic [2:0]      r_avail, n_avail;
    logic            r_done;

    logic                        in_acc, out_acc;
    logic                        eoi;
    logic [7:0]                  b;
    logic [5:0]                  s1, s2;
    logic                        has2;
    logic [bhh_pkg::CODE_W-1:0]  c1, c2;
    logic [bhh_pkg::LEN_W-1:0]   l1, l2;
    logic [ACC_W-1:0]            w1, w;
    logic [ACC_W+7:0]            ext;
    logic [4:0]                  tot;
    logic [1:0]                  nb;

    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign b       = i_in.data_byte;
    assign eoi     = i_in.end_of_input;

    assign i_in.ready = (r_avail == 3'd0) || ((r_avail == 3'd1) && o_out.ready);

    // Sextet split by group position
    always_comb begin
        s2   = 6'd0;
        has2 = 1'b0;
        case (r_phase)
            bhh_pkg::PH_SECOND: begin
                s1      = {r_left[1:0], b[7:4]};
                n_left  = b[3:0];
                n_phase = bhh_pkg::PH_THIRD;
                if (eoi) begin
                    s2   = {b[3:0], 2'b00};
                    has2 = 1'b1;
                end
            end
            bhh_pkg::PH_THIRD: begin
                s1      = {r_left[3:0], b[7:6]};
                s2      = b[5:0];
                has2    = 1'b1;
                n_left  = 4'd0;
                n_phase = bhh_pkg::PH_FIRST;
            end
            default: begin
                s1      = b[7:2];
                n_left  = {2'b00, b[1:0]};
                n_phase = bhh_pkg::PH_SECOND;
                if (eoi) begin
                    s2   = {b[1:0], 4'b0000};
                    has2 = 1'b1;
                end
            end
        endcase
    end

    // Code lookup, bit merge and byte cut
    always_comb begin
        c1  = bhh_pkg::CODE_BITS[s1];
        l1  = bhh_pkg::CODE_LEN[s1];
        c2  = has2 ? bhh_pkg::CODE_BITS[s2] : '0;
        l2  = has2 ? bhh_pkg::CODE_LEN[s2]  : '0;
        w1  = ({22'd0, r_acc} << l1) | {{(ACC_W-bhh_pkg::CODE_W){1'b0}}, c1};
        w   = (w1 << l2) | {{(ACC_W-bhh_pkg::CODE_W){1'b0}}, c2};
        tot = {1'b0, r_cnt} + {1'b0, l1} + {1'b0, l2};
        // at least five bits are pending here, so tot - 1 never wraps
        nb  = 2'((tot - 5'd1) >> 3);
        // ones below the word give the end-of-stream pad
        ext = {w, 8'hff};
        for (int k = 0; k < bhh_pkg::MAX_OUT; k++) begin
            n_bytes[k] = 8'(ext >> 5'(tot - 5'(8 * k)));
        end
        n_avail = {1'b0, nb} + {2'b00, eoi};
        n_acc   = w[7:0];
        n_cnt   = 4'(tot - {nb, 3'b000});
    end

    // Control and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bhh_pkg::PH_FIRST;
            r_left  <= 4'd0;
            r_acc   <= 8'd0;
            r_cnt   <= 4'd0;
            r_avail <= 3'd0;
            r_done  <= 1'b0;
        end else if (in_acc) begin
            r_avail <= n_avail;
            r_done  <= eoi;
            if (eoi) begin
                r_phase <= bhh_pkg::PH_FIRST;
                r_left  <= 4'd0;
                r_acc   <= 8'd0;
                r_cnt   <= 4'd0;
            end else begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_acc   <= n_acc;
                r_cnt   <= n_cnt;
            end
        end else if (out_acc) begin
            r_avail <= r_avail - 3'd1;
        end
    end

    // Result bytes: load on accept, shift down as they leave
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_bytes <= n_bytes;
        end else if (out_acc) begin
            for (int k = 0; k < bhh_pkg::MAX_OUT - 1; k++) begin
                r_bytes[k] <= r_bytes[k+1];
            end
        end
    end

    assign o_out.valid       = (r_avail != 3'd0);
    assign o_out.coded_byte  = r_bytes[0];
    assign o_out.stream_done = r_done && (r_avail == 3'd1);

`ifndef SYNTHESIS
    a_avail_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_avail <= 3'd4)
        else $error("result buffer count out of range");

    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'd8)
        else $error("more than eight bits held between transactions");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_avail <= 3'd1))
        else $error("input taken while result buffer still full");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && eoi) |=> (r_cnt == 4'd0) && (r_phase == bhh_pkg::PH_FIRST)
                            && o_out.valid && r_done)
        else $error("stream end did not clear state or raise a final byte");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready && o_out.stream_done) |=> o_out.stream_done)
        else $error("final byte flag dropped while stalled");
`endif

endmodule

`default_nettype wire
